// ----- hw/rtl/sf2d_pkg.sv -----
// Shared types, constants and helpers for the separable 2-D FIR filter.
// No dependencies; imported by every module of the block except sf2d_ram.
package sf2d_pkg;

  localparam int SAMPLE_BITS   = 16;
  localparam int COEF_BITS     = 16;
  localparam int COEF_COUNT    = 17;
  localparam int COEF_IDX_BITS = 5;
  localparam int COL_BITS      = 22;
  localparam int ACC_BITS      = 48;
  localparam int CFG_DATA_BITS = 64;
  localparam int CFG_IDX_BITS  = 3;
  localparam int TAP_CFG_BITS  = 5;
  localparam int WIDTH_CFG_BITS = 12;
  localparam int ROW_BITS      = 16;
  localparam int OUT_COL_BITS  = 11;
  localparam int TAP_IDX_BITS  = 6;   // covers MAX_TAPS up to 33
  localparam int DEF_MAX_TAPS  = 17;
  localparam int DEF_MAX_WIDTH = 2048;

  localparam logic [TAP_CFG_BITS-1:0]   RST_TAP_COUNT = 5'd5;
  localparam logic [WIDTH_CFG_BITS-1:0] RST_WIDTH     = 12'd2048;
  localparam logic [ROW_BITS-1:0]       RST_HEIGHT    = 16'd1080;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_TAP_COUNT, REG_IMAGE_WIDTH, REG_IMAGE_HEIGHT, REG_COEF_A,
    REG_COEF_B, REG_COEF_C, REG_COEF_D, REG_COEF_TAIL
  } cfg_reg_t;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] sample;
    logic                          frame_start;
  } in_item_t;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] filtered;
    logic [ROW_BITS-1:0]           out_row;
    logic [OUT_COL_BITS-1:0]       out_col;
    logic                          frame_last;
  } out_item_t;

  typedef enum logic [1:0] {SRC_MEM, SRC_SAMPLE, SRC_WINDOW} mac_src_t;

  typedef enum logic [3:0] {
    ST_CLEAR, ST_IDLE, ST_START, ST_COL_RUN, ST_COL_WAIT, ST_COL_DONE,
    ST_ROW_RUN, ST_ROW_WAIT, ST_RESULT, ST_UPDATE
  } state_t;

  typedef struct packed {
    logic                    clr_step;
    logic                    accept;
    logic                    acc_clr;
    logic                    mac_valid;
    mac_src_t                src;
    logic [TAP_IDX_BITS-1:0] k;
    logic                    col_done;
    logic                    out_load;
    logic                    update;
  } ctrl_cmd_t;

  typedef struct packed {
    logic                    clr_last;
    logic                    col_ok;
    logic                    row_ok;
    logic                    mac_busy;
    logic [TAP_IDX_BITS-1:0] taps;
  } dp_status_t;

  // Round by 15 bits (add half, floor) then clamp to a signed range of 'bits'.
  function automatic logic signed [ACC_BITS-1:0] round_sat(
      input logic signed [ACC_BITS-1:0] a, input int bits);
    logic signed [ACC_BITS-1:0] t;
    logic signed [ACC_BITS-1:0] hi;
    logic signed [ACC_BITS-1:0] lo;
    t  = a + $signed(ACC_BITS'(16384));
    t  = t >>> 15;
    hi = $signed((ACC_BITS'(1) << (bits - 1)) - ACC_BITS'(1));
    lo = ~hi;
    if (t > hi) begin
      return hi;
    end else if (t < lo) begin
      return lo;
    end
    return t;
  endfunction

endpackage

// ----- hw/rtl/separable_2d_fir_filter.sv -----
// Top level of the separable 2-D FIR filter: controller, datapath and line store.
// Depends on sf2d_pkg, sf2d_ctrl, sf2d_datapath, sf2d_ram.
//
// Usage:
//  - in_*  : valid/ready channel of raster-order samples; frame_start restarts
//            the position at row 0, column 0.
//  - out_* : valid/ready channel of filtered interior pixels with their row,
//            column and a frame_last flag on the last interior pixel.
//  - cfg_* : write-only register port (cfg_we, cfg_index, cfg_data); write only
//            while the block is idle.
//  - One item at a time. Per transfer, a column pass runs only when one is due,
//    and a row pass follows it only when a result is made. The bound is the
//    single shared multiply-accumulate unit, which takes one tap per cycle,
//    fed by one line-store read port.
//  - After reset the line store is cleared, one entry per cycle, all
//    (MAX_TAPS-1)*MAX_WIDTH entries (32768 by default); in_ready stays low.
//  - A stalled receiver holds the result in the output register; the next
//    sample is still taken and worked on, and waits only at its own result.
module separable_2d_fir_filter
  import sf2d_pkg::*;
#(
  parameter int MAX_TAPS  = DEF_MAX_TAPS,
  parameter int MAX_WIDTH = DEF_MAX_WIDTH
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  in_item_t                 in_item,
  output logic                     out_valid,
  input  logic                     out_ready,
  output out_item_t                out_item,
  input  logic                     cfg_we,
  input  logic [CFG_IDX_BITS-1:0]  cfg_index,
  input  logic [CFG_DATA_BITS-1:0] cfg_data
);
  ctrl_cmd_t  cmd;
  dp_status_t st;
  logic       out_free;

  // result slot free when empty or being taken this cycle
  assign out_free = !out_valid || out_ready;

  sf2d_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .out_free (out_free),
    .st       (st),
    .cmd      (cmd)
  );

  sf2d_datapath #(.MAX_TAPS(MAX_TAPS), .MAX_WIDTH(MAX_WIDTH)) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_item   (in_item),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .out_item  (out_item),
    .cmd       (cmd),
    .st        (st)
  );
endmodule

// ----- hw/rtl/sf2d_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module sf2d_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// ----- hw/rtl/sf2d_ctrl.sv -----
// Sequencer for the filter: clearing pass, column pass, row pass, result, update.
// Depends on sf2d_pkg.
module sf2d_ctrl
  import sf2d_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic       out_free,
  input  dp_status_t st,
  output ctrl_cmd_t  cmd
);
  state_t state_r, state_nxt;
  logic [TAP_IDX_BITS-1:0] k_r, k_nxt;
  logic last_k;

  assign last_k = (k_r == st.taps - TAP_IDX_BITS'(1));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
      k_r     <= '0;
    end else begin
      state_r <= state_nxt;
      k_r     <= k_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_CLEAR:    if (st.clr_last) state_nxt = ST_IDLE;
      ST_IDLE:     if (in_valid) state_nxt = ST_START;
      ST_START:    state_nxt = st.col_ok ? ST_COL_RUN : ST_UPDATE;
      ST_COL_RUN:  if (last_k) state_nxt = ST_COL_WAIT;
      ST_COL_WAIT: if (!st.mac_busy) state_nxt = ST_COL_DONE;
      ST_COL_DONE: state_nxt = st.row_ok ? ST_ROW_RUN : ST_UPDATE;
      ST_ROW_RUN:  if (last_k) state_nxt = ST_ROW_WAIT;
      ST_ROW_WAIT: if (!st.mac_busy) state_nxt = ST_RESULT;
      ST_RESULT:   if (out_free) state_nxt = ST_UPDATE;
      ST_UPDATE:   state_nxt = ST_IDLE;
      default:     state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd       = '0;
    cmd.src   = SRC_MEM;
    cmd.k     = k_r;
    in_ready  = 1'b0;
    k_nxt     = '0;
    case (state_r)
      ST_CLEAR: cmd.clr_step = 1'b1;
      ST_IDLE: begin
        in_ready   = 1'b1;
        cmd.accept = in_valid;
      end
      ST_START: cmd.acc_clr = 1'b1;
      ST_COL_RUN: begin
        cmd.mac_valid = 1'b1;
        cmd.src       = last_k ? SRC_SAMPLE : SRC_MEM;
        k_nxt         = k_r + TAP_IDX_BITS'(1);
      end
      ST_COL_DONE: begin
        cmd.col_done = 1'b1;
        cmd.acc_clr  = 1'b1;
      end
      ST_ROW_RUN: begin
        cmd.mac_valid = 1'b1;
        cmd.src       = SRC_WINDOW;
        k_nxt         = k_r + TAP_IDX_BITS'(1);
      end
      ST_RESULT: cmd.out_load = out_free;
      ST_UPDATE: cmd.update = 1'b1;
      default: ;
    endcase
  end
endmodule

// ----- hw/rtl/sf2d_datapath.sv -----
// Datapath: config registers, position counters, MAC pipeline, row window, result register.
// Depends on sf2d_pkg and sf2d_ram.
module sf2d_datapath
  import sf2d_pkg::*;
#(
  parameter int MAX_TAPS  = DEF_MAX_TAPS,
  parameter int MAX_WIDTH = DEF_MAX_WIDTH
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     cfg_we,
  input  logic [CFG_IDX_BITS-1:0]  cfg_index,
  input  logic [CFG_DATA_BITS-1:0] cfg_data,
  input  in_item_t                 in_item,
  input  logic                     out_ready,
  output logic                     out_valid,
  output out_item_t                out_item,
  input  ctrl_cmd_t                cmd,
  output dp_status_t               st
);
  localparam int LINE_ROWS = MAX_TAPS - 1;
  localparam int DEPTH     = LINE_ROWS * MAX_WIDTH;
  localparam int AW        = $clog2(DEPTH);
  localparam int CW        = $clog2(MAX_WIDTH);
  localparam int SW        = $clog2(LINE_ROWS);
  localparam int WIW       = $clog2(MAX_TAPS);
  localparam int PW        = COL_BITS + COEF_BITS;

  // configuration
  logic [TAP_CFG_BITS-1:0]       tap_count_r;
  logic [WIDTH_CFG_BITS-1:0]     width_r;
  logic [ROW_BITS-1:0]           height_r;
  logic signed [COEF_BITS-1:0]   coef_r [COEF_COUNT];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tap_count_r <= RST_TAP_COUNT;
      width_r     <= RST_WIDTH;
      height_r    <= RST_HEIGHT;
      for (int i = 0; i < COEF_COUNT; i++) coef_r[i] <= '0;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        REG_TAP_COUNT:    tap_count_r <= cfg_data[TAP_CFG_BITS-1:0];
        REG_IMAGE_WIDTH:  width_r <= cfg_data[WIDTH_CFG_BITS-1:0];
        REG_IMAGE_HEIGHT: height_r <= cfg_data[ROW_BITS-1:0];
        REG_COEF_A, REG_COEF_B, REG_COEF_C, REG_COEF_D: begin
          for (int i = 0; i < 4; i++)
            coef_r[(int'(cfg_index) - int'(REG_COEF_A)) * 4 + i] <=
              cfg_data[i*COEF_BITS +: COEF_BITS];
        end
        REG_COEF_TAIL:    coef_r[COEF_COUNT-1] <= cfg_data[COEF_BITS-1:0];
        default: ;
      endcase
    end
  end

  // effective sizes
  logic [TAP_IDX_BITS-1:0] taps, half;
  logic [CW:0]             w_eff;
  logic [ROW_BITS-1:0]     h_eff;

  always_comb begin
    if (tap_count_r == '0) taps = TAP_IDX_BITS'(1);
    else if (int'(tap_count_r) > MAX_TAPS) taps = TAP_IDX_BITS'(MAX_TAPS);
    else taps = TAP_IDX_BITS'(tap_count_r);
    half = taps >> 1;
    if (width_r == '0) w_eff = (CW+1)'(1);
    else if (int'(width_r) > MAX_WIDTH) w_eff = (CW+1)'(MAX_WIDTH);
    else w_eff = (CW+1)'(width_r);
    h_eff = (height_r == '0) ? ROW_BITS'(1) : height_r;
  end

  // position and sample
  logic [ROW_BITS-1:0]            r_r;
  logic [CW-1:0]                  c_r;
  logic [SW-1:0]                  slot_r, rd_slot_r;
  logic signed [SAMPLE_BITS-1:0]  sample_r;
  logic [SW-1:0]                  cur_slot, start_slot;
  logic [TAP_IDX_BITS-1:0]        tm1;
  logic [CW:0]                    c_inc;
  logic [ROW_BITS:0]              r_inc;

  assign tm1      = taps - TAP_IDX_BITS'(1);
  assign cur_slot = in_item.frame_start ? '0 : slot_r;
  assign start_slot = (int'(cur_slot) >= int'(tm1)) ?
                      SW'(int'(cur_slot) - int'(tm1)) :
                      SW'(int'(cur_slot) + LINE_ROWS - int'(tm1));
  assign c_inc = {1'b0, c_r} + (CW+1)'(1);
  assign r_inc = {1'b0, r_r} + (ROW_BITS+1)'(1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      r_r    <= '0;
      c_r    <= '0;
      slot_r <= '0;
    end else if (cmd.accept && in_item.frame_start) begin
      r_r    <= '0;
      c_r    <= '0;
      slot_r <= '0;
    end else if (cmd.update) begin
      if (c_inc >= w_eff) begin
        c_r <= '0;
        if (r_inc >= {1'b0, h_eff}) begin
          r_r    <= '0;
          slot_r <= '0;
        end else begin
          r_r    <= r_inc[ROW_BITS-1:0];
          slot_r <= (int'(slot_r) == LINE_ROWS - 1) ? '0 : slot_r + SW'(1);
        end
      end else begin
        c_r <= c_inc[CW-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      sample_r  <= in_item.sample;
      rd_slot_r <= start_slot;
    end else if (cmd.mac_valid && cmd.src == SRC_MEM) begin
      rd_slot_r <= (int'(rd_slot_r) == LINE_ROWS - 1) ? '0 : rd_slot_r + SW'(1);
    end
  end

  assign st.taps   = taps;
  assign st.col_ok = ({10'd0, tm1} <= r_r);
  assign st.row_ok = (int'(tm1) <= int'(c_r));

  // line store with clearing pass after reset
  logic [AW-1:0]          clr_cnt_r;
  logic                   ram_we;
  logic [AW-1:0]          ram_waddr, ram_raddr;
  logic [SAMPLE_BITS-1:0] ram_wdata, ram_rdata;

  always_ff @(posedge clk) begin
    if (!rst_n) clr_cnt_r <= '0;
    else if (cmd.clr_step) clr_cnt_r <= clr_cnt_r + AW'(1);
  end
  assign st.clr_last = (int'(clr_cnt_r) == DEPTH - 1);

  assign ram_we    = cmd.clr_step || cmd.update;
  assign ram_waddr = cmd.clr_step ? clr_cnt_r :
                     AW'(AW'(slot_r) * AW'(MAX_WIDTH) + AW'(c_r));
  assign ram_wdata = cmd.clr_step ? '0 : sample_r;
  assign ram_raddr = AW'(AW'(rd_slot_r) * AW'(MAX_WIDTH) + AW'(c_r));

  sf2d_ram #(.WIDTH(SAMPLE_BITS), .DEPTH(DEPTH)) u_line_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // MAC pipeline: stage 1 operand select (RAM data lands here), stage 2 product
  logic                         v1_r, v2_r;
  mac_src_t                     src1_r;
  logic [TAP_IDX_BITS-1:0]      k1_r;
  logic signed [COL_BITS-1:0]   win_r [MAX_TAPS];
  logic signed [COL_BITS-1:0]   opnd;
  logic signed [COEF_BITS-1:0]  cf;
  logic signed [PW-1:0]         prod, prod_r;
  logic signed [ACC_BITS-1:0]   acc_r;
  logic [WIW-1:0]               wi;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else begin
      v1_r <= cmd.mac_valid;
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    src1_r <= cmd.src;
    k1_r   <= cmd.k;
    prod_r <= prod;
  end

  assign wi = WIW'(MAX_TAPS - int'(taps) + int'(k1_r));

  always_comb begin
    case (src1_r)
      SRC_MEM:    opnd = $signed({{(COL_BITS-SAMPLE_BITS){ram_rdata[SAMPLE_BITS-1]}},
                                  ram_rdata});
      SRC_SAMPLE: opnd = $signed({{(COL_BITS-SAMPLE_BITS){sample_r[SAMPLE_BITS-1]}},
                                  sample_r});
      SRC_WINDOW: opnd = win_r[wi];
      default:    opnd = '0;
    endcase
    cf   = (int'(k1_r) < COEF_COUNT) ? coef_r[k1_r[COEF_IDX_BITS-1:0]] : '0;
    prod = opnd * cf;
  end

  assign st.mac_busy = v1_r || v2_r;

  always_ff @(posedge clk) begin
    if (cmd.acc_clr) acc_r <= '0;
    else if (v2_r) acc_r <= acc_r + $signed({{(ACC_BITS-PW){prod_r[PW-1]}}, prod_r});
  end

  // row window of column results
  logic signed [ACC_BITS-1:0] col_val, row_val;
  assign col_val = round_sat(acc_r, COL_BITS);
  assign row_val = round_sat(acc_r, SAMPLE_BITS);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < MAX_TAPS; i++) win_r[i] <= '0;
    end else if (cmd.col_done) begin
      for (int i = 0; i < MAX_TAPS - 1; i++) win_r[i] <= win_r[i+1];
      win_r[MAX_TAPS-1] <= col_val[COL_BITS-1:0];
    end
  end

  // result register
  logic      out_valid_r;
  out_item_t out_item_r;
  logic [CW-1:0] ocol;

  assign ocol = c_r - CW'(tm1) + CW'(half);

  always_ff @(posedge clk) begin
    if (!rst_n) out_valid_r <= 1'b0;
    else if (cmd.out_load) out_valid_r <= 1'b1;
    else if (out_ready) out_valid_r <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_item_r.filtered   <= row_val[SAMPLE_BITS-1:0];
      out_item_r.out_row    <= r_r - ROW_BITS'(tm1) + ROW_BITS'(half);
      out_item_r.out_col    <= OUT_COL_BITS'(ocol);
      out_item_r.frame_last <= (r_r == h_eff - ROW_BITS'(1)) &&
                               ({1'b0, c_r} == w_eff - (CW+1)'(1));
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;
endmodule

// ----- hw/rtl/sf2d_checker.sv -----
// Port-level checks for the separable 2-D FIR filter, bound to the top level.
// Depends on sf2d_pkg.
module sf2d_checker
  import sf2d_pkg::*;
(
  input logic      clk,
  input logic      rst_n,
  input logic      in_valid,
  input logic      in_ready,
  input logic      out_valid,
  input logic      out_ready,
  input out_item_t out_item
);
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_item))
    else $error("result changed while stalled");

  a_busy_after_in: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken while an item is in work");

  a_out_after_work: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(!in_ready))
    else $error("result appeared without an item in work");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid && !in_ready)
    else $error("channels active after reset");
endmodule

bind separable_2d_fir_filter sf2d_checker u_sf2d_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_item  (out_item)
);

// ----- tb/sv/separable_2d_fir_filter_tb.sv -----
// Self-checking testbench for separable_2d_fir_filter: raster frames in, interior pixels out.
// Depends on sf2d_pkg and the separable_2d_fir_filter RTL; an internal model predicts results.
`timescale 1ns / 100ps

module separable_2d_fir_filter_tb;
  import sf2d_pkg::*;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  in_item_t in_item = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_item_t out_item;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_BITS-1:0] cfg_index = '0;
  logic [CFG_DATA_BITS-1:0] cfg_data = '0;

  separable_2d_fir_filter dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_item(in_item),
    .out_valid(out_valid), .out_ready(out_ready), .out_item(out_item),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Filter model: own copy of registers, line store, row window and position.
  // ---------------------------------------------------------------------------
  logic [4:0]  m_taps;
  logic [11:0] m_width;
  logic [15:0] m_height;
  longint      m_coef [COEF_COUNT];
  logic signed [15:0] m_lines [16][2048];
  longint      m_window [17];
  int unsigned m_row;
  int unsigned m_col;

  out_item_t pending_pixels [$];
  int errors = 0;
  int items_sent = 0;
  bit steady = 1'b0;     // when set, neither side idles
  int hold_req = 0;      // receiver hold-off, counted down by the ready process

  function automatic longint round_q15(input longint a);
    return (a + 64'sd16384) >>> 15;
  endfunction

  function automatic longint clamp(input longint v, input int bits);
    longint hi;
    hi = (64'sd1 <<< (bits - 1)) - 1;
    if (v > hi) return hi;
    if (v < -hi - 1) return -hi - 1;
    return v;
  endfunction

  // Advance the model by one accepted sample; queue the pixel it produces, if any.
  function automatic void predict_pixel(input in_item_t it);
    int unsigned taps, half, w, h, r, c, slot;
    longint acc, colv, acc2;
    out_item_t px;
    taps = (m_taps == 0) ? 1 : (m_taps > 17) ? 17 : m_taps;
    half = taps / 2;
    w = (m_width == 0) ? 1 : (m_width > 2048) ? 2048 : m_width;
    h = (m_height == 0) ? 1 : m_height;
    if (it.frame_start) begin
      m_row = 0;
      m_col = 0;
    end
    r = m_row;
    c = m_col;
    if (r >= taps - 1) begin
      acc = 0;
      for (int k = 0; k + 1 < taps; k++) begin
        slot = (r - (taps - 1) + k) % 16;
        acc += m_coef[k] * longint'(m_lines[slot][c]);
      end
      acc += m_coef[taps-1] * longint'(it.sample);
      colv = clamp(round_q15(acc), COL_BITS);
      for (int k = 0; k < 16; k++) m_window[k] = m_window[k+1];
      m_window[16] = colv;
      if (c >= taps - 1) begin
        acc2 = 0;
        for (int k = 0; k < taps; k++) acc2 += m_coef[k] * m_window[17 - taps + k];
        px.filtered   = 16'(clamp(round_q15(acc2), SAMPLE_BITS));
        px.out_row    = 16'(r - (taps - 1) + half);
        px.out_col    = 11'(c - (taps - 1) + half);
        px.frame_last = (r == h - 1 && c == w - 1);
        pending_pixels.push_back(px);
      end
    end
    m_lines[r % 16][c] = it.sample;
    c++;
    if (c >= w) begin
      c = 0;
      r++;
      if (r >= h) r = 0;
    end
    m_row = r;
    m_col = c;
  endfunction

  // ---------------------------------------------------------------------------
  // Result checker: every output transfer is matched with the oldest prediction.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    out_item_t exp_px;
    if (rst_n && out_valid && out_ready) begin
      if (pending_pixels.size() == 0) begin
        $display("%0t: unexpected result, actual %p", $time, out_item);
        errors++;
      end else begin
        exp_px = pending_pixels.pop_front();
        if (out_item.filtered !== exp_px.filtered) begin
          $display("%0t: filtered expected %0d actual %0d", $time,
                   exp_px.filtered, out_item.filtered);
          errors++;
        end
        if (out_item.out_row !== exp_px.out_row) begin
          $display("%0t: out_row expected %0d actual %0d", $time,
                   exp_px.out_row, out_item.out_row);
          errors++;
        end
        if (out_item.out_col !== exp_px.out_col) begin
          $display("%0t: out_col expected %0d actual %0d", $time,
                   exp_px.out_col, out_item.out_col);
          errors++;
        end
        if (out_item.frame_last !== exp_px.frame_last) begin
          $display("%0t: frame_last expected %0d actual %0d", $time,
                   exp_px.frame_last, out_item.frame_last);
          errors++;
        end
      end
    end
  end

  // Receiver: random ~8% idling, none while steady, and long hold-offs on request.
  always @(posedge clk) begin
    if (hold_req > 0) begin
      hold_req--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= steady ? 1'b1 : ($urandom_range(99) >= 8);
    end
  end

  // ---------------------------------------------------------------------------
  // Shared tasks
  // ---------------------------------------------------------------------------
  task automatic apply_reset();
    m_taps = RST_TAP_COUNT;
    m_width = RST_WIDTH;
    m_height = RST_HEIGHT;
    foreach (m_coef[i]) m_coef[i] = 0;
    foreach (m_lines[i, j]) m_lines[i][j] = '0;
    foreach (m_window[i]) m_window[i] = 0;
    m_row = 0;
    m_col = 0;
    rst_n <= 1'b0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
  endtask

  // One transfer of the input channel; the model advances when it is accepted.
  task automatic send_item(input logic signed [15:0] s, input logic fs);
    in_item_t it;
    it.sample = s;
    it.frame_start = fs;
    if (!steady && $urandom_range(99) < 8) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item <= it;
    do @(posedge clk); while (!in_ready);
    predict_pixel(it);
    items_sent++;
  endtask

  // Wait for every predicted pixel, then let a column pass that makes no result finish.
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_pixels.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_reg_t idx, input logic [63:0] d);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= d;
    @(posedge clk);
    case (idx)
      REG_TAP_COUNT:    m_taps = d[4:0];
      REG_IMAGE_WIDTH:  m_width = d[11:0];
      REG_IMAGE_HEIGHT: m_height = d[15:0];
      REG_COEF_TAIL:    m_coef[16] = longint'($signed(d[15:0]));
      default: begin
        for (int i = 0; i < 4; i++)
          m_coef[(int'(idx) - int'(REG_COEF_A)) * 4 + i] = longint'($signed(d[16*i +: 16]));
      end
    endcase
  endtask

  // Write every register; coefficients passed as 17 values.
  task automatic configure(input int t, input int w, input int h, input logic [15:0] cf [17]);
    drain();
    write_reg(REG_TAP_COUNT, 64'(t));
    write_reg(REG_IMAGE_WIDTH, 64'(w));
    write_reg(REG_IMAGE_HEIGHT, 64'(h));
    write_reg(REG_COEF_A, {cf[3], cf[2], cf[1], cf[0]});
    write_reg(REG_COEF_B, {cf[7], cf[6], cf[5], cf[4]});
    write_reg(REG_COEF_C, {cf[11], cf[10], cf[9], cf[8]});
    write_reg(REG_COEF_D, {cf[15], cf[14], cf[13], cf[12]});
    write_reg(REG_COEF_TAIL, {48'd0, cf[16]});
    cfg_we <= 1'b0;
  endtask

  function automatic logic [15:0] rand_sample();
    case ($urandom_range(9))
      0: return 16'h7FFF;
      1: return 16'h8000;
      2: return 16'(int'($urandom_range(0, 255)) - 128);
      default: return 16'($urandom);
    endcase
  endfunction

  // Moderate taps in half the sets, so saturation is occasional; the rest are full-range.
  task automatic rand_coefs(output logic [15:0] cf [17]);
    int mode;
    mode = $urandom_range(3);
    foreach (cf[i]) begin
      if (mode == 0) cf[i] = 16'($urandom);
      else if (mode == 1) cf[i] = ($urandom_range(1) ? 16'h7FFF : 16'h8000);
      else cf[i] = 16'(int'($urandom_range(0, 8191)) - 4096);
    end
  endtask

  // Whole frame of w*h samples; a rare stray frame_start tests a mid-frame restart.
  task automatic send_frame(input int w, input int h);
    for (int i = 0; i < w * h; i++)
      send_item(rand_sample(), (i == 0) || ($urandom_range(499) == 0));
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------
  task automatic test_directed();
    logic [15:0] cf [17];
    // single tap: every sample is an interior pixel; full-scale gains of both signs
    foreach (cf[i]) cf[i] = 16'h0000;
    cf[0] = 16'h7FFF;
    configure(1, 4, 2, cf);
    send_item(16'h7FFF, 1'b1);
    send_item(16'h8000, 1'b0);
    send_item(16'h0001, 1'b0);
    send_item(16'hFFFF, 1'b0);
    cf[0] = 16'h8000;
    configure(0, 4, 2, cf);   // zero taps acts as one
    send_item(16'h8000, 1'b1);
    send_item(16'h7FFF, 1'b0);
    send_item(16'h0000, 1'b0);
    send_item(16'h4000, 1'b0);
    // three taps on a 4x4 frame, with a frame_start restarting mid-frame
    cf[0] = 16'h7FFF; cf[1] = 16'h8000; cf[2] = 16'h7FFF;
    configure(3, 4, 4, cf);
    for (int i = 0; i < 16; i++)
      send_item((i % 2) ? 16'h8000 : 16'h7FFF, (i == 0) || (i == 6));
  endtask

  task automatic test_tap_extremes();
    logic [15:0] cf [17];
    rand_coefs(cf);
    configure(17, 18, 17, cf);
    send_frame(18, 17);
    rand_coefs(cf);
    configure(31, 17, 18, cf);   // above the maximum acts as 17
    send_frame(17, 18);
  endtask

  task automatic test_size_limits();
    logic [15:0] cf [17];
    rand_coefs(cf);
    configure(1, 0, 0, cf);      // zero width and height act as one
    for (int i = 0; i < 8; i++) send_item(rand_sample(), $urandom_range(1));
    rand_coefs(cf);
    configure(2, 4095, 65535, cf);  // width clamps to the maximum row
    for (int i = 0; i < 40; i++) send_item(rand_sample(), i == 0);
    rand_coefs(cf);
    configure(1, 2048, 1, cf);
    for (int i = 0; i < 40; i++) send_item(rand_sample(), i == 0);
  endtask

  task automatic test_backpressure();
    logic [15:0] cf [17];
    rand_coefs(cf);
    configure(1, 8, 4, cf);
    hold_req = 600;              // receiver holds off while the sender keeps offering
    send_frame(8, 4);
  endtask

  // Large 17-tap frames only early on, so the total stays near the target.
  task automatic test_random_frames();
    logic [15:0] cf [17];
    int t, w, h;
    while (items_sent < 1550) begin
      t = (items_sent < 1000 && $urandom_range(9) == 0) ? 17 : $urandom_range(1, 6);
      w = t + $urandom_range(0, 8);
      h = t + $urandom_range(0, 4);
      rand_coefs(cf);
      configure(t, w, h, cf);
      steady = ($urandom_range(5) == 0);
      repeat ((t == 17) ? 1 : $urandom_range(1, 2)) send_frame(w, h);
      steady = 1'b0;
    end
  endtask

  initial begin
    apply_reset();
    test_directed();
    test_tap_extremes();
    test_size_limits();
    test_backpressure();
    test_random_frames();
    drain();
    if (errors == 0 && pending_pixels.size() == 0) begin
      $display("separable_2d_fir_filter_tb: clean");
    end else begin
      $display("separable_2d_fir_filter_tb: errors");
    end
    $finish;
  end

  initial begin
    #10ms;
    $display("separable_2d_fir_filter_tb: errors");
    $finish;
  end

endmodule
